// File: rtl/cd_pkg.sv
// Shared types and constants for the coordinate descent step block.
// Holds field widths, codes, reset values and the divider and table formats.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package cd_pkg;

  // Defaults for the top-level parameters.
  localparam int COORDINATES_DEF   = 1024;
  localparam int FRACTION_BITS_DEF = 16;

  // Field widths and packed stream widths.
  localparam int COORD_W    = 10;
  localparam int VAL_W      = 32;
  localparam int BOUND_W    = 31;
  localparam int S_DATA_W   = 112;
  localparam int S_USER_W   = 1;
  localparam int M_DATA_W   = 112;
  localparam int M_USER_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // Item kinds.
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_LOAD   = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_UPDATED = 2'd0;
  localparam logic [1:0] ST_FIXED   = 2'd1;
  localparam logic [1:0] ST_BAD_DEN = 2'd2;
  localparam logic [1:0] ST_LOADED  = 2'd3;

  // Prior modes.
  localparam logic [1:0] PRIOR_NONE    = 2'd0;
  localparam logic [1:0] PRIOR_LAPLACE = 2'd1;
  localparam logic [1:0] PRIOR_NORMAL  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PRIOR_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAPLACE_LAMBDA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_VARIANCE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_BOUND = 2'd3;

  // Configuration reset values.
  localparam logic [1:0]         PRIOR_MODE_RST    = PRIOR_LAPLACE;
  localparam logic [BOUND_W-1:0] LAMBDA_RST        = 31'd20724;
  localparam logic [BOUND_W-1:0] INV_VARIANCE_RST  = 31'd66;
  localparam logic [BOUND_W-1:0] INITIAL_BOUND_RST = 31'd131072;

  // One coefficient table entry.
  typedef struct packed {
    logic               fixed;
    logic [BOUND_W-1:0] bound;
    logic [VAL_W-1:0]   coef;
  } entry_t;

  // Divider request and response.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/coordinate_descent_step.sv
// Top level of the coordinate descent step block: sequencer, registers, stream ports.
// Instantiates cd_table and cd_div; types and codes come from cd_pkg.
`timescale 1ns / 1ps

// Usage:
// Input beats arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser carries the
// item kind (update or load). Each input beat yields exactly one result beat on
// m_tvalid/m_tready/m_tdata/m_tuser, with the status in m_tuser.
// Registers are written on the cfg channel (cfg_valid/cfg_ready, index, data);
// cfg_ready is always high and writes are expected only while the block is idle.
// A load, a skipped fixed coordinate, a bad denominator or an index out of range
// goes from the start step straight to the finish step. An update that divides
// passes launch, wait, post, clip and bounds, its pace set by the bit-serial
// divider that produces one quotient bit per cycle. Under the Laplace prior with a
// zero coefficient the divider may run twice. The block takes one item at a time;
// s_tready rises again in the same cycle that m_tvalid rises for its result.
// Reset: synchronous, active high. After reset a clearing pass writes every table
// row; s_tready stays low meanwhile.
// Stall: a result waits in the output register while m_tready is low; the next
// item is accepted but holds in its last step until the register frees.

module coordinate_descent_step #(
  parameter int COORDINATES   = cd_pkg::COORDINATES_DEF,
  parameter int FRACTION_BITS = cd_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // coordinate[9:0], gradient[41:10], curvature[73:42], load_value[105:74],
  // load_fixed[106], zero fill above
  input  logic [cd_pkg::S_DATA_W-1:0]   s_tdata,
  // kind[0]
  input  logic [cd_pkg::S_USER_W-1:0]   s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_coordinate[9:0], step[41:10], new_coefficient[73:42], new_bound[104:74],
  // zero fill above
  output logic [cd_pkg::M_DATA_W-1:0]   m_tdata,
  // status[1:0]
  output logic [cd_pkg::M_USER_W-1:0]   m_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cd_pkg::*;

  localparam int ADDR_W = (COORDINATES > 1) ? $clog2(COORDINATES) : 1;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_READ   = 11'b000_0000_0010,
    S_FETCH  = 11'b000_0000_0100,
    S_SETUP  = 11'b000_0000_1000,
    S_START  = 11'b000_0001_0000,
    S_LAUNCH = 11'b000_0010_0000,
    S_WAIT   = 11'b000_0100_0000,
    S_POST   = 11'b000_1000_0000,
    S_CLIP   = 11'b001_0000_0000,
    S_BOUNDS = 11'b010_0000_0000,
    S_FINISH = 11'b100_0000_0000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [1:0]         prior_mode;
  logic [BOUND_W-1:0] laplace_lambda;
  logic [BOUND_W-1:0] inverse_variance;
  logic [BOUND_W-1:0] initial_bound;

  // Captured input item.
  logic                     kind_r;
  logic [COORD_W-1:0]       coord_r;
  logic signed [VAL_W-1:0]  g_r;
  logic signed [VAL_W-1:0]  h_r;
  logic [VAL_W-1:0]         lv_r;
  logic                     lf_r;

  // Working registers.
  logic signed [VAL_W-1:0]  b_r;
  logic [BOUND_W-1:0]       bound_r;
  logic                     fixed_r;
  logic [62:0]              prod_r;
  logic signed [33:0]       den_r;
  logic signed [63:0]       t_s_r;
  logic signed [63:0]       num_a_r;
  logic signed [63:0]       num_b_r;
  logic                     second_r;
  logic signed [32:0]       d_r;

  // Result staged for the output register.
  logic [VAL_W-1:0]         res_step;
  logic [VAL_W-1:0]         res_coef;
  logic [BOUND_W-1:0]       res_bound;
  logic [1:0]               res_status;
  logic                     res_write;
  entry_t                   res_entry;

  // Output register.
  logic [COORD_W-1:0]       out_coord_r;
  logic [VAL_W-1:0]         out_step_r;
  logic [VAL_W-1:0]         out_coef_r;
  logic [BOUND_W-1:0]       out_bound_r;
  logic [1:0]               out_status_r;
  logic                     out_free;

  // Table and divider hookups.
  entry_t   rd_entry;
  logic     tbl_busy;
  logic     tbl_wr_en;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Decoded conditions and arithmetic.
  logic                     is_normal;
  logic                     is_laplace;
  logic                     b_zero;
  logic                     in_range;
  logic                     den_pos;
  logic [VAL_W-1:0]         b_mag;
  logic [62:0]              t_mag;
  logic signed [33:0]       den_next;
  logic signed [63:0]       g64;
  logic signed [63:0]       lam64;
  logic signed [63:0]       num_norm;
  logic signed [63:0]       num_neg;
  logic signed [63:0]       num_pos;
  logic signed [63:0]       num_none;
  logic signed [32:0]       q33;
  logic signed [32:0]       b33;
  logic signed [32:0]       bq_sum;
  logic signed [32:0]       neg_b;
  logic signed [32:0]       d_post;
  logic                     need_second;
  logic signed [32:0]       bnd33;
  logic signed [32:0]       d_clip;
  logic [VAL_W-1:0]         d_mag;
  logic [32:0]              twice;
  logic [32:0]              half;
  logic [32:0]              nb33;
  logic [BOUND_W-1:0]       nb;
  logic signed [32:0]       bd_sum;
  logic [VAL_W-1:0]         coef_sat;

  assign is_normal  = prior_mode == PRIOR_NORMAL;
  assign is_laplace = prior_mode == PRIOR_LAPLACE;
  assign b_zero     = b_r == '0;
  assign in_range   = 32'(coord_r) < 32'(COORDINATES);
  assign den_pos    = !den_r[33] && (den_r != '0);

  // Coefficient magnitude for the normal prior product and the denominator.
  always_comb begin
    b_mag    = rd_entry.coef[VAL_W-1] ? VAL_W'(-rd_entry.coef) : rd_entry.coef;
    den_next = $signed({{2{h_r[VAL_W-1]}}, h_r});
    if (is_normal) begin
      den_next = den_next + $signed({3'b000, inverse_variance});
    end
    t_mag = prod_r >> FRACTION_BITS;
  end

  // Numerators for each prior rule.
  always_comb begin
    g64      = {{32{g_r[VAL_W-1]}}, g_r};
    lam64    = $signed({33'd0, laplace_lambda});
    num_norm = -(g64 + t_s_r);
    num_neg  = lam64 - g64;
    num_pos  = -(g64 + lam64);
    num_none = -g64;
  end

  // Step selection once a quotient is back.
  always_comb begin
    q33         = {div_rsp.quot[31], div_rsp.quot};
    b33         = {b_r[VAL_W-1], b_r};
    bq_sum      = b33 + q33;
    neg_b       = -b33;
    d_post      = q33;
    need_second = 1'b0;
    if (is_laplace) begin
      if (b_zero) begin
        if (!second_r) begin
          if (!(q33 < 33'sd0)) begin
            need_second = 1'b1;
          end
        end else if (!(q33 > 33'sd0)) begin
          d_post = '0;
        end
      end else if (b_r[VAL_W-1]) begin
        // The step must not carry a negative coefficient past zero.
        if (bq_sum >= 33'sd0) begin
          d_post = neg_b;
        end
      end else begin
        if (bq_sum <= 33'sd0) begin
          d_post = neg_b;
        end
      end
    end
  end

  // Trust region clip.
  always_comb begin
    bnd33 = $signed({2'b00, bound_r});
    if (d_r < -bnd33) begin
      d_clip = -bnd33;
    end else if (d_r > bnd33) begin
      d_clip = bnd33;
    end else begin
      d_clip = d_r;
    end
  end

  // New bound and saturated coefficient.
  always_comb begin
    d_mag = d_r[32] ? VAL_W'(-d_r) : d_r[VAL_W-1:0];
    twice = {d_mag, 1'b0};
    half  = {3'b000, bound_r[BOUND_W-1:1]};
    nb33  = (twice > half) ? twice : half;
    nb    = (nb33 > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : nb33[BOUND_W-1:0];
    bd_sum = b33 + d_r;
    if (bd_sum[32] != bd_sum[31]) begin
      coef_sat = bd_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      coef_sat = bd_sum[VAL_W-1:0];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_mode       <= PRIOR_MODE_RST;
      laplace_lambda   <= LAMBDA_RST;
      inverse_variance <= INV_VARIANCE_RST;
      initial_bound    <= INITIAL_BOUND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PRIOR_MODE:     prior_mode       <= cfg_data[1:0];
        CFG_LAPLACE_LAMBDA: laplace_lambda   <= cfg_data;
        CFG_INV_VARIANCE:   inverse_variance <= cfg_data;
        CFG_INITIAL_BOUND:  initial_bound    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE) && !tbl_busy;
  assign out_free  = !m_tvalid || m_tready;
  assign tbl_wr_en = (state == S_FINISH) && out_free && res_write;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // The finish step sets the valid flag itself when it loads a new beat.
      if (m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            kind_r  <= s_tuser[0];
            coord_r <= s_tdata[9:0];
            g_r     <= s_tdata[41:10];
            h_r     <= s_tdata[73:42];
            lv_r    <= s_tdata[105:74];
            lf_r    <= s_tdata[106];
            state   <= S_READ;
          end
        end
        S_READ: begin
          state <= S_FETCH;
        end
        S_FETCH: begin
          b_r     <= rd_entry.coef;
          bound_r <= rd_entry.bound;
          fixed_r <= rd_entry.fixed;
          prod_r  <= 63'(b_mag) * 63'(inverse_variance);
          den_r   <= den_next;
          state   <= S_SETUP;
        end
        S_SETUP: begin
          t_s_r <= b_r[VAL_W-1] ? -$signed({1'b0, t_mag}) : $signed({1'b0, t_mag});
          state <= S_START;
        end
        S_START: begin
          res_step   <= '0;
          res_entry.fixed <= lf_r;
          res_entry.bound <= initial_bound;
          res_entry.coef  <= lv_r;
          second_r   <= 1'b0;
          num_b_r    <= num_pos;
          if (is_normal) begin
            num_a_r <= num_norm;
          end else if (is_laplace) begin
            num_a_r <= (b_r[VAL_W-1] || b_zero) ? num_neg : num_pos;
          end else begin
            num_a_r <= num_none;
          end
          if (!in_range) begin
            res_coef   <= '0;
            res_bound  <= '0;
            res_write  <= 1'b0;
            res_status <= ST_FIXED;
            state      <= S_FINISH;
          end else if (kind_r == KIND_LOAD) begin
            res_coef   <= lv_r;
            res_bound  <= initial_bound;
            res_status <= ST_LOADED;
            res_write  <= 1'b1;
            state      <= S_FINISH;
          end else begin
            res_coef   <= b_r;
            res_bound  <= bound_r;
            res_write  <= 1'b0;
            if (fixed_r) begin
              res_status <= ST_FIXED;
              state      <= S_FINISH;
            end else if (!den_pos) begin
              res_status <= ST_BAD_DEN;
              state      <= S_FINISH;
            end else begin
              state <= S_LAUNCH;
            end
          end
        end
        S_LAUNCH: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          if (need_second) begin
            second_r <= 1'b1;
            state    <= S_LAUNCH;
          end else begin
            d_r   <= d_post;
            state <= S_CLIP;
          end
        end
        S_CLIP: begin
          d_r   <= d_clip;
          state <= S_BOUNDS;
        end
        S_BOUNDS: begin
          res_step        <= d_r[VAL_W-1:0];
          res_coef        <= coef_sat;
          res_bound       <= nb;
          res_status      <= ST_UPDATED;
          res_write       <= 1'b1;
          res_entry.fixed <= 1'b0;
          res_entry.bound <= nb;
          res_entry.coef  <= coef_sat;
          state           <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            m_tvalid     <= 1'b1;
            out_coord_r  <= coord_r;
            out_step_r   <= res_step;
            out_coef_r   <= res_coef;
            out_bound_r  <= res_bound;
            out_status_r <= res_status;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Divider request.
  always_comb begin
    div_req.start = state == S_LAUNCH;
    div_req.num   = second_r ? num_b_r : num_a_r;
    div_req.den   = den_r[31:0];
  end

  cd_table #(
    .COORDINATES   (COORDINATES),
    .FRACTION_BITS (FRACTION_BITS),
    .ADDR_W        (ADDR_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (state == S_READ),
    .rd_addr (ADDR_W'(coord_r)),
    .rd_data (rd_entry),
    .wr_en   (tbl_wr_en),
    .wr_addr (ADDR_W'(coord_r)),
    .wr_data (res_entry),
    .busy    (tbl_busy)
  );

  cd_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Output packing.
  assign m_tdata = {7'd0, out_bound_r, out_coef_r, out_step_r, out_coord_r};
  assign m_tuser = out_status_r;

endmodule

// File: rtl/cd_div.sv
// Restoring fixed-point divider, one quotient bit per cycle.
// Computes sat(num * 2^F / den) truncated toward zero; depends on cd_pkg.
`timescale 1ns / 1ps

module cd_div #(
  parameter int FRACTION_BITS = cd_pkg::FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cd_pkg::div_req_t req,
  output cd_pkg::div_rsp_t rsp
);
  import cd_pkg::*;

  localparam int NW     = 64 + FRACTION_BITS;
  localparam int HI_W   = NW - 32;
  localparam int ITER   = 32;
  localparam int CNT_W  = $clog2(ITER);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_FMT  = 3'b100
  } dstate_t;

  dstate_t          state;
  logic             neg_r;
  logic             sat_r;
  logic [31:0]      rem_r;
  logic [31:0]      low_r;
  logic [31:0]      q_r;
  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      quot_r;
  logic             done_r;

  logic [63:0]      mag;
  logic [NW-1:0]    scaled;
  logic [HI_W-1:0]  hi;
  logic [32:0]      rem2;
  logic [32:0]      den33;
  logic             ge;
  logic [31:0]      qq;

  // Magnitude of the dividend scaled by the fraction bits.
  always_comb begin
    mag    = req.num[63] ? 64'(-req.num) : req.num;
    scaled = {mag, {FRACTION_BITS{1'b0}}};
    hi     = scaled[NW-1:32];
  end

  // One restoring step.
  always_comb begin
    den33 = {1'b0, req.den};
    rem2  = {rem_r, low_r[31]};
    ge    = rem2 >= den33;
  end

  // Quotient limited to 2^31 before the sign is applied.
  always_comb begin
    if (sat_r || q_r > 32'h8000_0000) begin
      qq = 32'h8000_0000;
    end else begin
      qq = q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state)
        D_IDLE: begin
          if (req.start) begin
            neg_r <= req.num[63];
            sat_r <= hi >= HI_W'(req.den);
            rem_r <= hi[31:0];
            low_r <= scaled[31:0];
            q_r   <= '0;
            cnt_r <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= ge ? 32'(rem2 - den33) : rem2[31:0];
          q_r   <= {q_r[30:0], ge};
          low_r <= {low_r[30:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(ITER - 1)) begin
            state <= D_FMT;
          end
        end
        D_FMT: begin
          if (neg_r) begin
            quot_r <= 32'(-qq);
          end else if (qq == 32'h8000_0000) begin
            quot_r <= 32'h7FFF_FFFF;
          end else begin
            quot_r <= qq;
          end
          done_r <= 1'b1;
          state  <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// File: rtl/cd_table.sv
// Coefficient, bound and fixed-flag table held in one memory.
// After reset a clearing pass writes the reset entry to every row; uses cd_pkg.
`timescale 1ns / 1ps

module cd_table #(
  parameter int COORDINATES   = cd_pkg::COORDINATES_DEF,
  parameter int FRACTION_BITS = cd_pkg::FRACTION_BITS_DEF,
  parameter int ADDR_W        = (COORDINATES > 1) ? $clog2(COORDINATES) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output cd_pkg::entry_t      rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  cd_pkg::entry_t      wr_data,
  output logic                busy
);
  import cd_pkg::*;

  localparam logic [ADDR_W-1:0]  LAST      = ADDR_W'(COORDINATES - 1);
  localparam logic [BOUND_W-1:0] BOUND_RST = BOUND_W'(2) << FRACTION_BITS;

  entry_t            mem [0:COORDINATES-1];
  entry_t            rst_entry;
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  always_comb begin
    rst_entry.fixed = 1'b0;
    rst_entry.bound = BOUND_RST;
    rst_entry.coef  = '0;
  end

  // Clearing sweep, one row per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= rst_entry;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign busy = clearing;

endmodule
